>>> design/cds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types, bounds and calendar helpers for the calendar day stepper.
// ----------------------------------------------------------------------------
package cds_pkg;

  // Field widths
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int STAMP_W  = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W + SECOND_W;
  localparam int TDATA_W  = ((STAMP_W + 7) / 8) * 8;

  // Divisibility by 25: q = (y * RECIP_25) >> RECIP_SHIFT is floor(y / 25)
  // for every 12-bit year.
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 17;
  localparam logic [RECIP_W-1:0] RECIP_25 = 13'd5243;
  localparam int QUOT_W      = 8;
  localparam int REM_W       = 5;

  typedef enum logic [0:0] {
    CMD_NEXT = 1'b0,
    CMD_PREV = 1'b1
  } cmd_e;

  // Packed with year in the top bits, so a plain unsigned compare of two
  // stamps orders them by year, month, day, hour, minute, second.
  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } stamp_t;

  localparam stamp_t LATE_BOUND  = '{year: 12'd2200, month: 4'd12, day: 5'd31,
                                     hour: 5'd23, minute: 6'd59, second: 6'd59};
  localparam stamp_t EARLY_BOUND = '{year: 12'd1700, month: 4'd1, day: 5'd1,
                                     hour: 5'd0, minute: 6'd0, second: 6'd1};

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAYS_28 = 5'd28;
  localparam logic [DAY_W-1:0] DAYS_29 = 5'd29;
  localparam logic [DAY_W-1:0] DAYS_30 = 5'd30;
  localparam logic [DAY_W-1:0] DAYS_31 = 5'd31;
  localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;

  // Normalized item between the leap stage and the step stage
  typedef struct packed {
    cmd_e             cmd;
    stamp_t           stamp;
    logic [DAY_W-1:0] days_cur;   // length of the current month
    logic [DAY_W-1:0] days_prev;  // length of the month before
  } norm_t;

  // Stepped item before the final bound check
  typedef struct packed {
    stamp_t stamp;
    logic   clamped;
  } step_t;

  function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                  input logic [MONTH_W-1:0] mo);
    logic [DAY_W-1:0] n;
    case (mo) inside
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: n = DAYS_30;
      MONTH_FEB: n = leap ? DAYS_29 : DAYS_28;
      default:   n = DAYS_31;
    endcase
    return n;
  endfunction

endpackage

>>> design/calendar_day_stepper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_day_stepper
// Steps a Gregorian date-time one day forward or back, clipped to the
// window 1700-01-01 00:00:01 .. 2200-12-31 23:59:59.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata (low bit up)                          tuser
// s_axis    in   year 12, month 4, day 5, hour 5, min 6,     cmd (0 next, 1 prev)
//                sec 6, zero pad to 40
// m_axis    out  same layout as s_axis                       clamped
//
// One request enters per cycle unless back pressure has filled the stages; each
// moves through year divide, leap/month clip, day step, bound check, output reg.
// Each stage holds its contents while the stage after it is full and stalled,
// so back pressure propagates without dropping or duplicating an item.
// Reset clears only the stage valid bits; the block holds no other state.
// ----------------------------------------------------------------------------
module calendar_day_stepper (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
  // second[37:32], zero[39:38]
  input  logic [cds_pkg::TDATA_W-1:0]   s_axis_tdata,
  // cmd[0]
  input  logic [0:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
  // second[37:32], zero[39:38]
  output logic [cds_pkg::TDATA_W-1:0]   m_axis_tdata,
  // clamped[0]
  output logic [0:0]                    m_axis_tuser
);
  import cds_pkg::*;

  stamp_t in_stamp;
  cmd_e   in_cmd;
  logic   norm_valid;
  logic   norm_ready;
  norm_t  norm_item;
  logic   step_valid;
  logic   step_ready;
  step_t  step_item;
  stamp_t out_stamp;
  logic   out_clamped;

  // Unpack the request; tdata carries the fields with year lowest
  assign in_stamp.year   = s_axis_tdata[11:0];
  assign in_stamp.month  = s_axis_tdata[15:12];
  assign in_stamp.day    = s_axis_tdata[20:16];
  assign in_stamp.hour   = s_axis_tdata[25:21];
  assign in_stamp.minute = s_axis_tdata[31:26];
  assign in_stamp.second = s_axis_tdata[37:32];
  assign in_cmd          = cmd_e'(s_axis_tuser[0]);

  // Stages 1-2: year / 25, leap rule, month lengths, month and day clip
  cds_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_cmd    (in_cmd),
    .in_stamp  (in_stamp),
    .out_valid (norm_valid),
    .out_ready (norm_ready),
    .out_item  (norm_item)
  );

  // Stage 3: input bound check and day roll
  cds_step u_step (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (norm_valid),
    .in_ready  (norm_ready),
    .in_item   (norm_item),
    .out_valid (step_valid),
    .out_ready (step_ready),
    .out_item  (step_item)
  );

  // Stage 4: result bound check, output register
  cds_clamp u_clamp (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (step_valid),
    .in_ready    (step_ready),
    .in_item     (step_item),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_stamp   (out_stamp),
    .out_clamped (out_clamped)
  );

  // Pack the result the same way as the request, pad bits held at zero
  assign m_axis_tdata = {{(TDATA_W-STAMP_W){1'b0}}, out_stamp.second, out_stamp.minute,
                         out_stamp.hour, out_stamp.day, out_stamp.month, out_stamp.year};
  assign m_axis_tuser = out_clamped;

endmodule

>>> design/cds_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cds_norm
// Two pipeline stages: clip the month and divide the year by 25, then resolve
// the leap rule and month lengths and clip the day into range.
// ----------------------------------------------------------------------------
module cds_norm (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cds_pkg::cmd_e   in_cmd,
  input  cds_pkg::stamp_t in_stamp,
  output logic            out_valid,
  input  logic            out_ready,
  output cds_pkg::norm_t  out_item
);
  import cds_pkg::*;

  // Stage A: registered input with month clipped and year quotient by 25
  logic                         a_valid;
  cmd_e                         a_cmd;
  stamp_t                       a_stamp;
  logic [QUOT_W-1:0]            a_quot;
  logic                         a_ready;
  logic [YEAR_W+RECIP_W-1:0]    prod;
  stamp_t                       a_stamp_next;

  // Stage B
  logic                         b_ready;
  logic [QUOT_W+REM_W-1:0]      quot_x25;
  logic [YEAR_W-1:0]            rem_full;
  logic [REM_W-1:0]             rem25;
  logic                         leap;
  logic [DAY_W-1:0]             days_cur;
  logic [DAY_W-1:0]             days_prev;
  logic [DAY_W-1:0]             day_clip;
  norm_t                        b_next;

  assign prod = YEAR_W'(0) + ({RECIP_W'(0), in_stamp.year} * {YEAR_W'(0), RECIP_25});

  always_comb begin
    a_stamp_next = in_stamp;
    if (in_stamp.month < MONTH_JAN) begin
      a_stamp_next.month = MONTH_JAN;
    end else if (in_stamp.month > MONTH_DEC) begin
      a_stamp_next.month = MONTH_DEC;
    end else begin
      a_stamp_next.month = in_stamp.month;
    end
  end

  assign b_ready  = !out_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_cmd   <= in_cmd;
      a_stamp <= a_stamp_next;
      a_quot  <= prod[RECIP_SHIFT +: QUOT_W];
    end
  end

  // Leap: divisible by 4 and not by 100, or by 400 (16 and 25)
  always_comb begin
    quot_x25 = {1'b0, a_quot, 4'b0000} + {2'b00, a_quot, 3'b000} + {5'b00000, a_quot};
    rem_full = a_stamp.year - quot_x25[YEAR_W-1:0];
    rem25    = rem_full[REM_W-1:0];
    leap     = ((a_stamp.year[1:0] == 2'b00) && (rem25 != '0)) ||
               ((a_stamp.year[3:0] == 4'b0000) && (rem25 == '0));
    days_cur = month_days(leap, a_stamp.month);
    if (a_stamp.month == MONTH_JAN) begin
      days_prev = DAYS_31;
    end else begin
      days_prev = month_days(leap, a_stamp.month - MONTH_JAN);
    end
    if (a_stamp.day < DAY_FIRST) begin
      day_clip = DAY_FIRST;
    end else if (a_stamp.day > days_cur) begin
      day_clip = days_cur;
    end else begin
      day_clip = a_stamp.day;
    end
    b_next           = '{cmd: a_cmd, stamp: a_stamp, days_cur: days_cur,
                         days_prev: days_prev};
    b_next.stamp.day = day_clip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      out_item <= b_next;
    end
  end

endmodule

>>> design/cds_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cds_step
// One pipeline stage: check the input against the bounds and roll the date
// one day forward or back.
// ----------------------------------------------------------------------------
module cds_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cds_pkg::norm_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output cds_pkg::step_t out_item
);
  import cds_pkg::*;

  step_t  nxt;
  stamp_t t;

  assign t        = in_item.stamp;
  assign in_ready = !out_valid || out_ready;

  always_comb begin
    nxt.stamp   = t;
    nxt.clamped = 1'b0;
    if ((in_item.cmd == CMD_NEXT) && (t >= LATE_BOUND)) begin
      nxt.stamp   = LATE_BOUND;
      nxt.clamped = 1'b1;
    end else if ((in_item.cmd == CMD_PREV) && (t <= EARLY_BOUND)) begin
      nxt.stamp   = EARLY_BOUND;
      nxt.clamped = 1'b1;
    end else if (in_item.cmd == CMD_NEXT) begin
      if (t.day == in_item.days_cur) begin
        nxt.stamp.day = DAY_FIRST;
        if (t.month == MONTH_DEC) begin
          nxt.stamp.month = MONTH_JAN;
          nxt.stamp.year  = t.year + YEAR_W'(1);
        end else begin
          nxt.stamp.month = t.month + MONTH_W'(1);
        end
      end else begin
        nxt.stamp.day = t.day + DAY_W'(1);
      end
    end else begin
      if (t.day == DAY_FIRST) begin
        nxt.stamp.day = in_item.days_prev;
        if (t.month == MONTH_JAN) begin
          nxt.stamp.month = MONTH_DEC;
          nxt.stamp.year  = t.year - YEAR_W'(1);
        end else begin
          nxt.stamp.month = t.month - MONTH_W'(1);
        end
      end else begin
        nxt.stamp.day = t.day - DAY_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= nxt;
    end
  end

endmodule

>>> design/cds_clamp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cds_clamp
// Output stage: hold the stepped result inside the bounds and register it.
// ----------------------------------------------------------------------------
module cds_clamp (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cds_pkg::step_t  in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output cds_pkg::stamp_t out_stamp,
  output logic            out_clamped
);
  import cds_pkg::*;

  stamp_t r_next;
  logic   clamped_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    r_next       = in_item.stamp;
    clamped_next = in_item.clamped;
    if (in_item.stamp >= LATE_BOUND) begin
      r_next       = LATE_BOUND;
      clamped_next = 1'b1;
    end else if (in_item.stamp <= EARLY_BOUND) begin
      r_next       = EARLY_BOUND;
      clamped_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_stamp   <= r_next;
      out_clamped <= clamped_next;
    end
  end

  a_clamp_is_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_clamped |-> (out_stamp == LATE_BOUND) || (out_stamp == EARLY_BOUND))
    else $error("clamped result is not a bound");

  a_year_window: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_stamp.year >= 12'd1700) && (out_stamp.year <= 12'd2200))
    else $error("result year outside window");

  a_date_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_stamp.month >= MONTH_JAN) && (out_stamp.month <= MONTH_DEC) &&
                  (out_stamp.day >= DAY_FIRST))
    else $error("result month or day out of range");

  a_inner_unclamped: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_clamped |-> (out_stamp < LATE_BOUND) && (out_stamp > EARLY_BOUND))
    else $error("unclamped result on or past a bound");

endmodule

>>> verif/tb_calendar_day_stepper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_day_stepper
// Self-checking bench for the calendar day stepper. Requests (a date-time and
// a next/previous-day command) are queued by a stimulus process and fed by a
// clocked driver. A clocked monitor predicts each result at input acceptance
// and compares it against the output stream in order. Runs directed calendar
// corner cases, then random dates under several idle/stall mixes and one long
// output hold-off.
// ----------------------------------------------------------------------------
module tb_calendar_day_stepper;
  import cds_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int PRINT_LIMIT = 100;

  typedef struct {
    cmd_e   cmd;
    stamp_t stamp;
  } day_request_t;

  typedef struct packed {
    stamp_t stamp;
    logic   clamped;
  } day_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata  = '0;
  logic [0:0]         s_axis_tuser  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [0:0]         m_axis_tuser;

  day_request_t pending_requests[$];
  day_result_t  expected_dates[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_start   = 1'b0;
  int hold_left      = 0;

  int mismatches    = 0;
  int requests_sent = 0;
  int dates_checked = 0;
  int clamps_seen   = 0;
  int leap_days     = 0;
  int cycles        = 0;

  always #5 clk = ~clk;

  calendar_day_stepper u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // --------------------------------------------------------------------------
  // Calendar predictor
  // --------------------------------------------------------------------------
  function automatic int month_length(int yr, int mo);
    bit leap;
    leap = (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
    case (mo)
      4, 6, 9, 11: return 30;
      2:           return leap ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  function automatic day_result_t step_date(cmd_e cmd, stamp_t raw);
    stamp_t t;
    stamp_t r;
    int last_day;
    logic clip;
    t = raw;
    clip = 1'b0;
    // Fold an out-of-range month or day onto the nearest legal one
    if (t.month < 1) t.month = MONTH_W'(1);
    if (t.month > 12) t.month = MONTH_W'(12);
    last_day = month_length(t.year, t.month);
    if (t.day < 1) t.day = DAY_W'(1);
    if (t.day > last_day) t.day = DAY_W'(last_day);
    r = t;
    if (cmd == CMD_NEXT && t >= LATE_BOUND) begin
      r = LATE_BOUND;
      clip = 1'b1;
    end else if (cmd == CMD_PREV && t <= EARLY_BOUND) begin
      r = EARLY_BOUND;
      clip = 1'b1;
    end else if (cmd == CMD_NEXT) begin
      if (t.day == last_day) begin
        r.day = DAY_W'(1);
        if (t.month == 12) begin
          r.month = MONTH_W'(1);
          r.year  = t.year + YEAR_W'(1);
        end else begin
          r.month = t.month + MONTH_W'(1);
        end
      end else begin
        r.day = t.day + DAY_W'(1);
      end
    end else begin
      if (t.day == 1) begin
        if (t.month == 1) begin
          r.month = MONTH_W'(12);
          r.year  = t.year - YEAR_W'(1);
        end else begin
          r.month = t.month - MONTH_W'(1);
        end
        r.day = DAY_W'(month_length(r.year, r.month));
      end else begin
        r.day = t.day - DAY_W'(1);
      end
    end
    // Clip the stepped date into the window; touching a bound counts too
    if (r >= LATE_BOUND) begin
      r = LATE_BOUND;
      clip = 1'b1;
    end else if (r <= EARLY_BOUND) begin
      r = EARLY_BOUND;
      clip = 1'b1;
    end
    return '{stamp: r, clamped: clip};
  endfunction

  function automatic stamp_t unpack_stamp(logic [TDATA_W-1:0] v);
    stamp_t s;
    s.year   = v[11:0];
    s.month  = v[15:12];
    s.day    = v[20:16];
    s.hour   = v[25:21];
    s.minute = v[31:26];
    s.second = v[37:32];
    return s;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("[%0t] result %0d: %s got %0d, want %0d", $time, dates_checked, field,
               got, want);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer the next queued request, or idle at random
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        day_request_t rq;
        rq = pending_requests.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rq.cmd;
        s_axis_tdata  <= {2'b00, rq.stamp.second, rq.stamp.minute, rq.stamp.hour,
                          rq.stamp.day, rq.stamp.month, rq.stamp.year};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Long output hold-off, counted down in its own process
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: stall at random, or hard while a hold-off runs
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict at request acceptance, check each result in order
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_dates.push_back(step_date(cmd_e'(s_axis_tuser[0]),
                                           unpack_stamp(s_axis_tdata)));
        requests_sent++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_dates.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          day_result_t want;
          stamp_t got;
          want = expected_dates.pop_front();
          got  = unpack_stamp(m_axis_tdata);
          if (got.year != want.stamp.year)
            report_mismatch("year", got.year, want.stamp.year);
          if (got.month != want.stamp.month)
            report_mismatch("month", got.month, want.stamp.month);
          if (got.day != want.stamp.day)
            report_mismatch("day", got.day, want.stamp.day);
          if (got.hour != want.stamp.hour)
            report_mismatch("hour", got.hour, want.stamp.hour);
          if (got.minute != want.stamp.minute)
            report_mismatch("minute", got.minute, want.stamp.minute);
          if (got.second != want.stamp.second)
            report_mismatch("second", got.second, want.stamp.second);
          if (m_axis_tdata[TDATA_W-1:STAMP_W] != '0)
            report_mismatch("pad", m_axis_tdata[TDATA_W-1:STAMP_W], 0);
          if (m_axis_tuser[0] != want.clamped)
            report_mismatch("clamped", m_axis_tuser[0], want.clamped);
          if (want.clamped) clamps_seen++;
          if (want.stamp.month == 2 && want.stamp.day == 29) leap_days++;
        end
        dates_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_dates.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic add_request(cmd_e cmd, int yr, int mo, int dy, int hr, int mi, int sc);
    day_request_t rq;
    rq.cmd          = cmd;
    rq.stamp.year   = YEAR_W'(yr);
    rq.stamp.month  = MONTH_W'(mo);
    rq.stamp.day    = DAY_W'(dy);
    rq.stamp.hour   = HOUR_W'(hr);
    rq.stamp.minute = MINUTE_W'(mi);
    rq.stamp.second = SECOND_W'(sc);
    pending_requests.push_back(rq);
  endtask

  // Mostly legal dates, biased to month ends and the window edges; some raw
  // field noise so every bit and every fold-up case gets hit.
  task automatic add_random_request();
    int pick, yr, mo, dy, len, hr, mi, sc;
    cmd_e cmd;
    pick = $urandom_range(99);
    cmd  = cmd_e'($urandom_range(1));
    if (pick < 15) begin
      add_request(cmd, $urandom_range(4095), $urandom_range(15), $urandom_range(31),
                  $urandom_range(31), $urandom_range(63), $urandom_range(63));
    end else begin
      if (pick < 35) begin
        yr = $urandom_range(1) ? $urandom_range(2199, 2201) : $urandom_range(1699, 1701);
        mo = $urandom_range(1) ? ((yr >= 2199) ? 12 : 1) : $urandom_range(1, 12);
      end else begin
        yr = $urandom_range(1690, 2210);
        mo = $urandom_range(1, 12);
      end
      len = month_length(yr, mo);
      case ($urandom_range(3))
        0:       dy = 1;
        1:       dy = len;
        2:       dy = $urandom_range(1, len);
        default: dy = $urandom_range(len - 1, len);
      endcase
      if (pick < 35 && $urandom_range(1)) begin
        hr = $urandom_range(1) ? 23 : 0;
        mi = $urandom_range(1) ? 59 : 0;
        sc = $urandom_range(1) ? $urandom_range(57, 59) : $urandom_range(0, 2);
      end else begin
        hr = $urandom_range(23);
        mi = $urandom_range(59);
        sc = $urandom_range(59);
      end
      add_request(cmd, yr, mo, dy, hr, mi, sc);
    end
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_dates.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) add_random_request();
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Leap rule: every fourth year, not centuries, but every fourth century
    add_request(CMD_NEXT, 2000, 2, 28, 12, 30, 45);
    add_request(CMD_NEXT, 1900, 2, 28, 6, 15, 0);
    add_request(CMD_NEXT, 2004, 2, 29, 0, 0, 0);
    add_request(CMD_PREV, 2004, 3, 1, 23, 59, 59);
    add_request(CMD_PREV, 2100, 3, 1, 8, 8, 8);
    // Year and short-month rollover
    add_request(CMD_NEXT, 1999, 12, 31, 23, 59, 59);
    add_request(CMD_PREV, 2000, 1, 1, 0, 0, 0);
    add_request(CMD_NEXT, 2001, 4, 30, 1, 2, 3);
    add_request(CMD_PREV, 2050, 1, 1, 10, 20, 30);
    // Latest bound: at it, stepping past it, landing exactly on it, leaving it
    add_request(CMD_NEXT, 2200, 12, 31, 23, 59, 59);
    add_request(CMD_NEXT, 2200, 12, 31, 23, 59, 58);
    add_request(CMD_NEXT, 2200, 12, 30, 23, 59, 59);
    add_request(CMD_PREV, 2200, 12, 31, 23, 59, 59);
    add_request(CMD_NEXT, 4095, 1, 1, 0, 0, 0);
    // Earliest bound, same set of cases from the other side
    add_request(CMD_PREV, 1700, 1, 1, 0, 0, 1);
    add_request(CMD_PREV, 1700, 1, 2, 0, 0, 1);
    add_request(CMD_PREV, 1700, 1, 2, 0, 0, 2);
    add_request(CMD_NEXT, 1699, 12, 31, 0, 0, 0);
    add_request(CMD_NEXT, 1700, 1, 1, 0, 0, 0);
    // Field extremes and out-of-range month, day and time values
    add_request(CMD_NEXT, 0, 0, 0, 0, 0, 0);
    add_request(CMD_PREV, 4095, 15, 31, 31, 63, 63);
    add_request(CMD_NEXT, 2010, 13, 0, 12, 0, 0);
    add_request(CMD_PREV, 2010, 2, 31, 3, 4, 5);
    add_request(CMD_NEXT, 2012, 6, 31, 9, 9, 9);
    add_request(CMD_NEXT, 2050, 7, 15, 31, 63, 63);
    wait_drained();

    run_phase(0, 0, 150);
    run_phase(67, 0, 150);
    run_phase(0, 67, 150);
    run_phase(26, 26, 150);

    // Back pressure: keep offering while the output holds off long enough
    // for the pipeline to fill and drop its input ready
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (90) add_random_request();
    hold_start = 1'b1;
    @(negedge clk);
    hold_start = 1'b0;
    wait_drained();

    run_phase(0, 0, 60);

    // Let any stray result surface before closing
    repeat (10) @(negedge clk);

    $display("checked %0d results from %0d requests: %0d clamped, %0d landing on Feb 29",
             dates_checked, requests_sent, clamps_seen, leap_days);
    $display("covered leap rules, month/year rollover, both window bounds, field folding");
    if (mismatches == 0 && expected_dates.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
